[sv/hsia_pkg.sv]
// ----------------------------------------------------------------------------
// Hash slot insert allocator package
// Shared constants for the hash slot insert allocator: field widths, reset
// values of the allocation state and the hash fold constants.
// ----------------------------------------------------------------------------
package hsia_pkg;

  localparam int SLOT_DEPTH_DEF = 8192;

  localparam int KEY_W      = 8;
  localparam int LEN_W      = 16;
  localparam int ADDR_W     = 32;
  localparam int SLOT_OUT_W = 13;
  localparam int CFG_W      = 14;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 14'd8192;

  localparam logic [ADDR_W-1:0] HASH_MULT    = 32'd131;
  localparam logic [ADDR_W-1:0] NODE_BYTES   = 32'd16;
  localparam logic [ADDR_W-1:0] INDEX_SLACK  = 32'd8192;
  localparam logic [ADDR_W-1:0] DATA_INITIAL = 32'd8388608;

  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

endpackage

[sv/hsia_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hsia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/hash_slot_insert_allocator_top.sv]
// ----------------------------------------------------------------------------
// Hash slot insert allocator
// Folds key bytes into a BKDR hash, reduces it to a slot and allocates a
// node address and a data offset when the slot is empty.
// ----------------------------------------------------------------------------
// A key byte that is not the last one is taken while the block stays idle,
// so such bytes can follow each other on every clock. The last byte of a
// key keeps busy high while the compare-subtract unit reduces the hash
// modulo the slot count one bit per cycle, and while the READ, CHECK and
// GROW states read the slot RAM, update it and settle the region sizes. The
// result appears on the out_ ports for one cycle in the cycle that busy
// falls, and it cannot be held off by the receiver, so it must be taken at
// once. After reset busy stays high while the slot RAM is cleared.
// The slot count register can be written at any time the block is idle.
// ----------------------------------------------------------------------------
module hash_slot_insert_allocator_top #(
  parameter int SLOT_DEPTH = hsia_pkg::SLOT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsia_pkg::KEY_W-1:0]      in_key_byte,
  input  logic                            in_key_last,
  input  logic [hsia_pkg::LEN_W-1:0]      in_data_length,
  input  logic                            cfg_we,
  input  logic [hsia_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic                            out_inserted,
  output logic [hsia_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic [hsia_pkg::ADDR_W-1:0]     out_node_address,
  output logic [hsia_pkg::ADDR_W-1:0]     out_data_offset,
  output logic                            out_index_grew,
  output logic                            out_data_grew,
  output logic [hsia_pkg::ADDR_W-1:0]     out_index_size_now,
  output logic [hsia_pkg::ADDR_W-1:0]     out_data_size_now
);

  localparam int AW = $clog2(SLOT_DEPTH);
  localparam int SW = $clog2(SLOT_DEPTH + 1);
  localparam int DW = hsia_pkg::ADDR_W;
  localparam int LW = hsia_pkg::LEN_W;

  localparam logic [DW-1:0] INDEX_HEADER = DW'(16 + 4 * SLOT_DEPTH);
  localparam logic [DW-1:0] INDEX_INIT   = INDEX_HEADER + hsia_pkg::INDEX_SLACK;
  localparam logic [DW-1:0] DEPTH_W      = DW'(SLOT_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(SLOT_DEPTH - 1);
  localparam logic [hsia_pkg::STEP_W-1:0] LAST_STEP =
    hsia_pkg::STEP_W'(hsia_pkg::DIV_STEPS - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_GROW  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [hsia_pkg::CFG_W-1:0]   slots_r, slots_nxt;
  logic [DW-1:0]                hash_r, hash_nxt;
  logic [LW-1:0]                cnt_r, cnt_nxt;
  logic [SW-1:0]                div_r, div_nxt;
  logic [SW-1:0]                rem_r, rem_nxt;
  logic [DW-1:0]                dvd_r, dvd_nxt;
  logic [hsia_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [LW-1:0]                key_len_r, key_len_nxt;
  logic [LW-1:0]                dlen_r, dlen_nxt;
  logic [DW-1:0]                next_node_r, next_node_nxt;
  logic [DW-1:0]                next_data_r, next_data_nxt;
  logic [DW-1:0]                index_size_r, index_size_nxt;
  logic [DW-1:0]                data_size_r, data_size_nxt;
  logic [LW:0]                  node_size_r, node_size_nxt;
  logic [DW-1:0]                idx_room_r, idx_room_nxt;
  logic                         hit_r, hit_nxt;
  logic [DW-1:0]                node_out_r, node_out_nxt;
  logic [DW-1:0]                data_out_r, data_out_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ins_r, out_ins_nxt;
  logic [hsia_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [DW-1:0]                out_node_r, out_node_nxt;
  logic [DW-1:0]                out_data_r, out_data_nxt;
  logic                         out_igrew_r, out_igrew_nxt;
  logic                         out_dgrew_r, out_dgrew_nxt;
  logic [DW-1:0]                out_isize_r, out_isize_nxt;
  logic [DW-1:0]                out_dsize_r, out_dsize_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [DW-1:0]                ram_wdata;
  logic [DW-1:0]                ram_rdata;

  logic                         accept;
  logic [DW-1:0]                sext;
  logic [DW-1:0]                hash_fold;
  logic [SW:0]                  trial;
  logic [DW-1:0]                eff_slots;
  logic [DW-1:0]                slots_ext;
  logic [LW:0]                  node_size;
  logic                         igrow;
  logic                         dgrow;

  hsia_ram #(
    .WIDTH (DW),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rem_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign sext   = {{(DW - hsia_pkg::KEY_W){in_key_byte[hsia_pkg::KEY_W-1]}}, in_key_byte};
  assign hash_fold = hash_r * hsia_pkg::HASH_MULT + sext;
  assign trial     = {rem_r, dvd_r[DW-1]};
  assign slots_ext = DW'(slots_r);
  assign node_size = (LW + 1)'(hsia_pkg::NODE_BYTES) + {1'b0, key_len_r};
  assign igrow     = hit_r && (idx_room_r < DW'(node_size_r));
  assign dgrow     = hit_r && (next_data_r >= data_size_r);

  always_comb begin
    priority if (slots_ext == '0) begin
      eff_slots = DW'(1);
    end else if (slots_ext > DEPTH_W) begin
      eff_slots = DEPTH_W;
    end else begin
      eff_slots = slots_ext;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    slots_nxt      = cfg_we ? cfg_wdata : slots_r;
    hash_nxt       = hash_r;
    cnt_nxt        = cnt_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    step_nxt       = step_r;
    key_len_nxt    = key_len_r;
    dlen_nxt       = dlen_r;
    next_node_nxt  = next_node_r;
    next_data_nxt  = next_data_r;
    index_size_nxt = index_size_r;
    data_size_nxt  = data_size_r;
    node_size_nxt  = node_size_r;
    idx_room_nxt   = idx_room_r;
    hit_nxt        = hit_r;
    node_out_nxt   = node_out_r;
    data_out_nxt   = data_out_r;
    out_valid_nxt  = 1'b0;
    out_ins_nxt    = out_ins_r;
    out_slot_nxt   = out_slot_r;
    out_node_nxt   = out_node_r;
    out_data_nxt   = out_data_r;
    out_igrew_nxt  = out_igrew_r;
    out_dgrew_nxt  = out_dgrew_r;
    out_isize_nxt  = out_isize_r;
    out_dsize_nxt  = out_dsize_r;
    ram_we         = 1'b0;
    ram_waddr      = rem_r[AW-1:0];
    ram_wdata      = next_node_r;

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_key_last) begin
            dvd_nxt     = hash_fold;
            rem_nxt     = '0;
            div_nxt     = eff_slots[SW-1:0];
            step_nxt    = '0;
            key_len_nxt = cnt_r + LW'(1);
            dlen_nxt    = in_data_length;
            hash_nxt    = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_DIV;
          end else begin
            hash_nxt = hash_fold;
            cnt_nxt  = cnt_r + LW'(1);
          end
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = SW'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[SW-1:0];
        end
        dvd_nxt  = {dvd_r[DW-2:0], 1'b0};
        step_nxt = step_r + hsia_pkg::STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        hit_nxt       = (ram_rdata == '0);
        node_size_nxt = node_size;
        if (ram_rdata == '0) begin
          ram_we        = 1'b1;
          node_out_nxt  = next_node_r;
          next_node_nxt = next_node_r + DW'(node_size);
          idx_room_nxt  = index_size_r - next_node_r;
          data_out_nxt  = next_data_r;
          next_data_nxt = next_data_r + DW'(dlen_r);
        end else begin
          node_out_nxt  = '0;
          data_out_nxt  = '0;
        end
        state_nxt = ST_GROW;
      end
      ST_GROW: begin
        if (igrow) begin
          index_size_nxt = {index_size_r[DW-2:0], 1'b0};
        end
        if (dgrow) begin
          data_size_nxt = {data_size_r[DW-2:0], 1'b0};
        end
        out_valid_nxt = 1'b1;
        out_ins_nxt   = hit_r;
        out_slot_nxt  = hsia_pkg::SLOT_OUT_W'(rem_r);
        out_node_nxt  = node_out_r;
        out_data_nxt  = data_out_r;
        out_igrew_nxt = igrow;
        out_dgrew_nxt = dgrow;
        out_isize_nxt = index_size_nxt;
        out_dsize_nxt = data_size_nxt;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_cnt_r    <= '0;
      slots_r      <= hsia_pkg::SLOT_COUNT_RST;
      hash_r       <= '0;
      cnt_r        <= '0;
      next_node_r  <= INDEX_HEADER;
      next_data_r  <= '0;
      index_size_r <= INDEX_INIT;
      data_size_r  <= hsia_pkg::DATA_INITIAL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      slots_r      <= slots_nxt;
      hash_r       <= hash_nxt;
      cnt_r        <= cnt_nxt;
      next_node_r  <= next_node_nxt;
      next_data_r  <= next_data_nxt;
      index_size_r <= index_size_nxt;
      data_size_r  <= data_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    step_r      <= step_nxt;
    key_len_r   <= key_len_nxt;
    dlen_r      <= dlen_nxt;
    node_size_r <= node_size_nxt;
    idx_room_r  <= idx_room_nxt;
    hit_r       <= hit_nxt;
    node_out_r  <= node_out_nxt;
    data_out_r  <= data_out_nxt;
    out_ins_r   <= out_ins_nxt;
    out_slot_r  <= out_slot_nxt;
    out_node_r  <= out_node_nxt;
    out_data_r  <= out_data_nxt;
    out_igrew_r <= out_igrew_nxt;
    out_dgrew_r <= out_dgrew_nxt;
    out_isize_r <= out_isize_nxt;
    out_dsize_r <= out_dsize_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_inserted       = out_ins_r;
  assign out_slot_index     = out_slot_r;
  assign out_node_address   = out_node_r;
  assign out_data_offset    = out_data_r;
  assign out_index_grew     = out_igrew_r;
  assign out_data_grew      = out_dgrew_r;
  assign out_index_size_now = out_isize_r;
  assign out_data_size_now  = out_dsize_r;

`ifndef SYNTHESIS
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result transfer repeated on consecutive cycles");

  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_key_last) |=> (state_r == ST_DIV))
    else $error("last key byte did not start the reduction");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (rem_r < div_r))
    else $error("slot remainder not below the slot count");

  a_occupied_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ins_r) |-> (out_node_r == '0 && out_data_r == '0 &&
      !out_igrew_r && !out_dgrew_r))
    else $error("occupied slot result carries an allocation");
`endif

endmodule
